/* design/shared_buffer_multi_queue_defines.svh */
// assertion macros for the queue rtl
`ifndef SHARED_BUFFER_MULTI_QUEUE_DEFINES_SVH
`define SHARED_BUFFER_MULTI_QUEUE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SBMQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SBMQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sbmq_pkg.sv */
package sbmq_pkg;

  localparam int SLOTS      = 64;
  localparam int QUEUES     = 4;
  localparam int DATA_WIDTH = 32;

  // fixed field widths of the ports
  localparam int ValueW = 32;
  localparam int QIdxW  = 2;

  localparam int SlotW  = $clog2(SLOTS);
  localparam int LinkW  = $clog2(SLOTS + 1);
  localparam int QSelW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  typedef logic [SlotW-1:0]      slot_t;
  typedef logic [LinkW-1:0]      link_t;
  typedef logic [QSelW-1:0]      qsel_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  // null link code
  localparam link_t NIL = link_t'(SLOTS);

  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

endpackage

/* design/sbmq_ram.sv */
module sbmq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/shared_buffer_multi_queue.sv */
// Several FIFO queues sharing one slot store, kept as linked lists with a
// free list of unused slots.
// Command channel: an operation transfers at the rising edge where start is
// high and busy is low; kind_i selects push (value_i) or pop, queue_index_i
// the queue. Each operation gives exactly one result: result_valid_o is high
// for one cycle with ok_o and popped_value_o. ok_o is low when a push finds
// the store full, a pop finds the queue empty, or the queue index is out of
// range; popped_value_o is zero except on a successful pop.
// The result is registered: an accepted operation moves the state to EXEC,
// and result_valid_o is set from EXEC. busy is high in the cycle after the
// transfer, so no new operation is taken until EXEC ends; this is set by the
// registered read of the link memory, whose entry is written back in EXEC.
// The receiver cannot stall: a result is on the ports for one cycle only.
// Reset: all queues empty, every slot free in ascending order. Untouched
// slots are tracked by an allocation counter, so no clearing pass is needed
// and the block accepts operations right after reset.
`include "shared_buffer_multi_queue_defines.svh"

module shared_buffer_multi_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             kind_i,
  input  logic [sbmq_pkg::QIdxW-1:0]       queue_index_i,
  input  logic signed [sbmq_pkg::ValueW-1:0] value_i,
  output logic                             result_valid_o,
  output logic                             ok_o,
  output logic signed [sbmq_pkg::ValueW-1:0] popped_value_o
);

  import sbmq_pkg::*;

  state_e state_q, state_d;
  link_t  free_head_q, free_head_d;
  link_t  fresh_q, fresh_d;
  link_t  head_q [QUEUES];
  link_t  tail_q [QUEUES];

  logic   op_pop_q;
  qsel_t  qsel_q;
  slot_t  slot_q;
  logic   op_ok_q;

  logic              result_valid_q;
  logic              ok_q;
  logic [ValueW-1:0] popped_q;

  qsel_t  qsel;
  logic   q_in_range;
  link_t  head_sel, tail_sel;
  logic   accept, is_pop;
  logic   free_valid, head_valid, tail_valid;
  logic   op_ok;
  slot_t  rd_slot;
  logic   exec;

  logic   link_we;
  slot_t  link_waddr;
  link_t  link_wdata;
  link_t  link_rdata;
  logic   data_we;
  data_t  data_rdata;

  assign qsel       = QSelW'(queue_index_i);
  assign q_in_range = (32'(queue_index_i) < 32'(QUEUES));
  assign head_sel   = head_q[qsel];
  assign tail_sel   = tail_q[qsel];
  assign accept     = start && !busy;
  assign is_pop     = (kind_i == OP_POP);
  assign free_valid = (free_head_q < NIL);
  assign head_valid = (head_sel < NIL);
  assign tail_valid = (tail_sel < NIL);
  assign op_ok      = q_in_range && (is_pop ? head_valid : free_valid);
  assign rd_slot    = is_pop ? head_sel[SlotW-1:0] : free_head_q[SlotW-1:0];
  assign exec       = (state_q == ST_EXEC);

  // state machine
  always_comb begin
    state_d = state_q;
    busy    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy    = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // link memory write: tail relink on transfer, slot update on completion
  always_comb begin
    link_we    = 1'b0;
    link_waddr = slot_q;
    link_wdata = NIL;
    priority if (accept && !is_pop && op_ok && head_valid && tail_valid) begin
      link_we    = 1'b1;
      link_waddr = tail_sel[SlotW-1:0];
      link_wdata = free_head_q;
    end else if (exec && op_ok_q) begin
      link_we    = 1'b1;
      link_waddr = slot_q;
      link_wdata = op_pop_q ? free_head_q : NIL;
    end else begin
      link_we    = 1'b0;
    end
  end

  assign data_we = accept && !is_pop && op_ok;

  sbmq_ram #(
    .Width (LinkW),
    .Depth (SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (rd_slot),
    .rdata_o (link_rdata)
  );

  sbmq_ram #(
    .Width (DATA_WIDTH),
    .Depth (SLOTS)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (free_head_q[SlotW-1:0]),
    .wdata_i (DATA_WIDTH'(unsigned'(value_i))),
    .raddr_i (rd_slot),
    .rdata_o (data_rdata)
  );

  // free list head and allocation counter
  always_comb begin
    free_head_d = free_head_q;
    fresh_d     = fresh_q;
    if (exec && op_ok_q) begin
      if (op_pop_q) begin
        free_head_d = link_t'(slot_q);
      end else if (link_t'(slot_q) == fresh_q) begin
        // never-allocated slot links to the next one
        free_head_d = link_t'(fresh_q + link_t'(1));
        fresh_d     = link_t'(fresh_q + link_t'(1));
      end else begin
        free_head_d = link_rdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      fresh_q     <= '0;
    end else begin
      free_head_q <= free_head_d;
      fresh_q     <= fresh_d;
    end
  end

  // queue heads and tails
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUEUES; i++) begin
        head_q[i] <= NIL;
        tail_q[i] <= NIL;
      end
    end else if (exec && op_ok_q) begin
      if (op_pop_q) begin
        head_q[qsel_q] <= link_rdata;
      end else begin
        if (!(head_q[qsel_q] < NIL)) begin
          head_q[qsel_q] <= link_t'(slot_q);
        end
        tail_q[qsel_q] <= link_t'(slot_q);
      end
    end
  end

  // operation held across the memory read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_pop_q <= is_pop;
      qsel_q   <= qsel;
      slot_q   <= rd_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_ok_q <= 1'b0;
    end else if (accept) begin
      op_ok_q <= op_ok;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      ok_q     <= op_ok_q;
      popped_q <= (op_ok_q && op_pop_q) ? ValueW'(data_rdata) : '0;
    end
  end

  assign result_valid_o = result_valid_q;
  assign ok_o           = ok_q;
  assign popped_value_o = signed'(popped_q);

  `SBMQ_ASSERT_NXT(a_result_follows, exec, result_valid_q && !busy, "result missing after exec")
  `SBMQ_ASSERT_IMP(a_free_head_bound, 1'b1, free_head_q <= fresh_q, "free head not allocated")
  `SBMQ_ASSERT_IMP(a_head_allocated, accept && q_in_range && head_valid, head_sel < fresh_q, "queue head never allocated")
  `SBMQ_ASSERT_IMP(a_failed_zero, result_valid_q && !ok_q, popped_q == '0, "failed result not zero")

endmodule

/* tb/tb_shared_buffer_multi_queue.sv */
module tb_shared_buffer_multi_queue;
  import sbmq_pkg::*;

  localparam int RANDOM_ITEMS  = 1150;
  localparam int STALL_LIMIT   = 2000;
  localparam int DIRECTED_ROWS = 20;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic              ok;
    logic [ValueW-1:0] value;
  } outcome_t;

  typedef struct packed {
    op_e               op;
    logic [QIdxW-1:0]  q;
    logic [ValueW-1:0] value;
    logic              typed;
    logic              ok;
    logic [ValueW-1:0] popped;
  } stim_row_t;

  // typed rows: results that follow directly from an empty store
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{OP_POP,  2'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
    '{OP_POP,  2'd3, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{OP_PUSH, 2'd0, 32'h8000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{OP_PUSH, 2'd0, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
    '{OP_PUSH, 2'd3, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
    '{OP_PUSH, 2'd3, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{OP_PUSH, 2'd1, 32'h0000_0001, 1'b1, 1'b1, 32'h0000_0000},
    '{OP_POP,  2'd0, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{OP_POP,  2'd0, 32'h5555_5555, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{OP_POP,  2'd0, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{OP_PUSH, 2'd0, 32'h1234_5678, 1'b0, 1'b0, 32'h0000_0000},
    '{OP_POP,  2'd3, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{OP_PUSH, 2'd2, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0000_0000},
    '{OP_POP,  2'd1, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0001},
    '{OP_POP,  2'd1, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{OP_POP,  2'd2, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{OP_POP,  2'd0, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{OP_POP,  2'd3, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{OP_POP,  2'd3, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{OP_POP,  2'd2, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              kind_i = 1'b0;
  logic [QIdxW-1:0]  queue_index_i = '0;
  logic [ValueW-1:0] value_i = '0;
  logic              result_valid_o;
  logic              ok_o;
  logic [ValueW-1:0] popped_value_o;

  shared_buffer_multi_queue DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .queue_index_i  (queue_index_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .ok_o           (ok_o),
    .popped_value_o (popped_value_o)
  );

  always #2 clk_i = ~clk_i;

  // shadow of the slot store, its links and the queue pointers
  data_t    slot_value [SLOTS];
  link_t    slot_next  [SLOTS];
  link_t    q_first    [QUEUES];
  link_t    q_last     [QUEUES];
  link_t    free_first;
  outcome_t pending_results [$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       burst_left = 0;

  function automatic void clear_queue_model();
    for (int i = 0; i < SLOTS; i++) begin
      slot_value[i] = '0;
      slot_next[i]  = (i + 1 < SLOTS) ? link_t'(i + 1) : NIL;
    end
    for (int i = 0; i < QUEUES; i++) begin
      q_first[i] = NIL;
      q_last[i]  = NIL;
    end
    free_first = '0;
  endfunction

  function automatic outcome_t apply_queue_op(op_e op, logic [QIdxW-1:0] q,
                                              logic [ValueW-1:0] v);
    outcome_t res;
    link_t    s;
    res = '0;
    if (int'(q) >= QUEUES) return res;
    if (op == OP_PUSH) begin
      s = free_first;
      if (s >= NIL) return res;
      free_first = slot_next[s[SlotW-1:0]];
      if (q_first[q] >= NIL) q_first[q] = s;
      else if (q_last[q] < NIL) slot_next[q_last[q][SlotW-1:0]] = s;
      slot_next[s[SlotW-1:0]] = NIL;
      q_last[q] = s;
      slot_value[s[SlotW-1:0]] = data_t'(v);
      res.ok = 1'b1;
    end else begin
      s = q_first[q];
      if (s >= NIL) return res;
      q_first[q] = slot_next[s[SlotW-1:0]];
      slot_next[s[SlotW-1:0]] = free_first;
      free_first = s;
      res.ok = 1'b1;
      res.value = ValueW'(slot_value[s[SlotW-1:0]]);
    end
    return res;
  endfunction

  function automatic int pick_burst();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
  endfunction

  task automatic send_op(op_e op, logic [QIdxW-1:0] q, logic [ValueW-1:0] v,
                         logic typed, outcome_t typed_res);
    outcome_t res;
    start         <= 1'b1;
    kind_i        <= op;
    queue_index_i <= q;
    value_i       <= v;
    do @(posedge clk_i); while (busy);
    res = apply_queue_op(op, q, v);
    pending_results.push_back(typed ? typed_res : res);
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat (($urandom_range(0, 5) == 0) ? $urandom_range(4, 15) : $urandom_range(1, 3))
        @(posedge clk_i);
      burst_left = pick_burst();
    end
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string field, logic [ValueW-1:0] want,
                                 logic [ValueW-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s: expected %h, got %h", field, want, got);
  endtask

  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", '0, popped_value_o);
      end else begin
        want = pending_results.pop_front();
        if (ok_o !== want.ok) report_mismatch("ok", ValueW'(want.ok), ValueW'(ok_o));
        if (popped_value_o !== want.value)
          report_mismatch("popped_value", want.value, popped_value_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t         row;
    outcome_t          typed_res;
    int                sent;
    int                phase;
    int                phase_len;
    int                push_pct;
    int                focus;
    op_e               op;
    logic [QIdxW-1:0]  qsel;
    logic [ValueW-1:0] val;

    clear_queue_model();
    burst_left = pick_burst();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      typed_res.ok = row.ok;
      typed_res.value = row.popped;
      send_op(row.op, row.q, row.value, row.typed, typed_res);
    end
    wait_for_drain();

    // first phase fills the store past full, the second only pops
    sent = 0;
    phase = 0;
    typed_res = '0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 0) begin
        push_pct = 100;
      end else if (phase == 1) begin
        push_pct = 0;
      end else begin
        case ($urandom_range(0, 4))
          0: push_pct = 100;
          1: push_pct = 85;
          2: push_pct = 50;
          3: push_pct = 20;
          default: push_pct = 0;
        endcase
      end
      phase_len = (phase < 2) ? 80 : $urandom_range(20, 80);
      focus = ($urandom_range(0, 1) == 1) ? $urandom_range(0, QUEUES - 1) : -1;
      repeat (phase_len) begin
        op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        if (focus >= 0 && $urandom_range(0, 3) != 0) qsel = QIdxW'(focus);
        else qsel = QIdxW'($urandom_range(0, (1 << QIdxW) - 1));
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0: val = 32'h0000_0000;
            1: val = 32'hFFFF_FFFF;
            2: val = 32'h8000_0000;
            default: val = 32'h7FFF_FFFF;
          endcase
        end else begin
          val = $urandom;
        end
        send_op(op, qsel, val, 1'b0, typed_res);
        sent++;
      end
      if ($urandom_range(0, 1) == 1) wait_for_drain();
      phase++;
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/sbmq_pkg.sv
design/sbmq_ram.sv
design/shared_buffer_multi_queue.sv
tb/tb_shared_buffer_multi_queue.sv
